// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the cipher RTL.
// Depends on nothing; each macro takes the clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/teactr_pkg.sv =====
// Shared types, constants and helper functions of the TEA counter-mode cipher.
// Used by the front, back and top modules of the block; depends on nothing.
package teactr_pkg;

    localparam int ROUND_COUNT_DEF     = 32;
    localparam int QUEUE_DEPTH_DEF     = 4;
    localparam int OUT_QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] TEA_DELTA     = 32'h9e3779b9;
    localparam logic [3:0]  BLOCK_BYTES   = 4'd8;
    localparam logic [3:0]  POS_EXHAUSTED = 4'd8;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE     = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       new_block;
        logic [2:0] byte_index;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } cfg_write_t;

    // One half of a TEA round: the value added to the other word.
    function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                            input logic [31:0] ka, input logic [31:0] kb);
        tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    // Keystream byte taken little-endian, low word first.
    function automatic logic [7:0] block_byte(input logic [63:0] blk, input logic [2:0] idx);
        block_byte = blk[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/teactr_fifo.sv =====
// Small first-in first-out queue built from registers.
// Generic in width and depth; used between front and back and on the result side.
`include "assert_macros.svh"

module teactr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_CLK(a_fifo_count_up, clk, rst_n, (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1), "fifo count did not follow a lone write")
    `ASSERT_NEVER(a_fifo_overfill, clk, rst_n, count_reg > CNT_W'(DEPTH), "fifo count beyond depth")

endmodule

// ===== rtl/teactr_front.sv =====
// Front end: accepts input bytes and tags each with its keystream byte slot.
// Tracks the position inside the current block; depends on teactr_pkg.
`include "assert_macros.svh"

module teactr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    input  logic               stream_start,
    input  logic               q_full,
    output logic               q_wr,
    output teactr_pkg::item_t  q_item
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       accept;
    logic       new_block;

    assign accept    = push && !q_full;
    assign new_block = stream_start || (pos_reg >= teactr_pkg::BLOCK_BYTES);

    always_comb
    begin
        q_item.data_byte  = data_byte;
        q_item.restart    = stream_start;
        q_item.new_block  = new_block;
        q_item.byte_index = new_block ? 3'd0 : pos_reg[2:0];
        pos_next          = pos_reg;
        if (accept)
        begin
            pos_next = new_block ? 4'd1 : pos_reg + 4'd1;
        end
    end

    assign q_wr = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= teactr_pkg::POS_EXHAUSTED;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    `ASSERT_NEVER(a_front_pos_range, clk, rst_n, pos_reg > teactr_pkg::POS_EXHAUSTED, "block position beyond block end")

endmodule

// ===== rtl/teactr_back.sv =====
// Back end: key and nonce registers, the iterative TEA round unit with a one-block
// prefetch, and the byte XOR. Depends on teactr_pkg.
`include "assert_macros.svh"

module teactr_back #(
    parameter int ROUND_COUNT = teactr_pkg::ROUND_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  teactr_pkg::cfg_write_t cfg,
    input  logic                   head_valid,
    input  teactr_pkg::item_t      head,
    output logic                   head_pop,
    input  logic                   out_full,
    output logic                   out_wr,
    output logic [7:0]             out_data
);

    localparam int RC_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    logic [31:0]     key0_reg;
    logic [31:0]     key1_reg;
    logic [31:0]     key2_reg;
    logic [31:0]     key3_reg;
    logic [31:0]     nonce_reg;
    logic [31:0]     ctr_reg;
    logic [63:0]     ks_reg;
    logic [63:0]     pre_reg;
    logic [31:0]     pre_ctr_reg;
    logic            pre_valid_reg;
    logic            busy_reg;
    logic [31:0]     run_ctr_reg;
    logic [31:0]     a_reg;
    logic [31:0]     b_reg;
    logic [31:0]     acc_reg;
    logic [RC_W-1:0] rounds_reg;

    logic [31:0] want;
    logic        pre_hit;
    logic        consume_new;
    logic        start_run;
    logic        last_round;
    logic [31:0] acc_next;
    logic [31:0] a_next;
    logic [31:0] b_next;

    // The block counter the round unit should have ready for the next new block.
    assign want    = (head_valid && head.new_block && head.restart) ? '0 : ctr_reg;
    assign pre_hit = pre_valid_reg && (pre_ctr_reg == want);

    assign head_pop    = head_valid && !out_full && (!head.new_block || pre_hit);
    assign out_wr      = head_pop;
    assign consume_new = head_pop && head.new_block;
    assign out_data    = head.data_byte ^ teactr_pkg::block_byte(
                             head.new_block ? pre_reg : ks_reg, head.byte_index);

    assign start_run  = !cfg.valid && !pre_hit && (!busy_reg || (run_ctr_reg != want));
    assign last_round = (rounds_reg == RC_W'(ROUND_COUNT - 1));

    always_comb
    begin
        acc_next = acc_reg + teactr_pkg::TEA_DELTA;
        a_next   = a_reg + teactr_pkg::tea_mix(b_reg, acc_next, key0_reg, key1_reg);
        b_next   = b_reg + teactr_pkg::tea_mix(a_next, acc_next, key2_reg, key3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce_reg     <= '0;
            ctr_reg       <= '0;
            pre_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    teactr_pkg::CFG_KEY_WORD0: key0_reg  <= cfg.data;
                    teactr_pkg::CFG_KEY_WORD1: key1_reg  <= cfg.data;
                    teactr_pkg::CFG_KEY_WORD2: key2_reg  <= cfg.data;
                    teactr_pkg::CFG_KEY_WORD3: key3_reg  <= cfg.data;
                    teactr_pkg::CFG_NONCE:     nonce_reg <= cfg.data;
                    default: ;
                endcase
                // Any prefetched or running block was made under the old settings.
                pre_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
            else if (consume_new)
            begin
                ctr_reg       <= want + 32'd1;
                pre_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
            else if (start_run)
            begin
                busy_reg <= 1'b1;
            end
            else if (pre_hit)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && last_round)
            begin
                busy_reg      <= 1'b0;
                pre_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume_new)
        begin
            ks_reg <= pre_reg;
        end
        if (start_run)
        begin
            a_reg       <= nonce_reg;
            b_reg       <= want;
            acc_reg     <= '0;
            rounds_reg  <= '0;
            run_ctr_reg <= want;
        end
        else if (busy_reg)
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            acc_reg    <= acc_next;
            rounds_reg <= rounds_reg + 1'b1;
            if (last_round)
            begin
                pre_reg     <= {b_next, a_next};
                pre_ctr_reg <= run_ctr_reg;
            end
        end
    end

    `ASSERT_CLK(a_back_cfg_flush, clk, rst_n, cfg.valid |=> (!pre_valid_reg && !busy_reg), "settings write left a stale block")
    `ASSERT_CLK(a_back_ctr_step, clk, rst_n, consume_new |=> (ctr_reg == $past(want) + 32'd1), "block counter did not advance past the used block")
    `ASSERT_NEVER(a_back_round_range, clk, rst_n, busy_reg && (rounds_reg > RC_W'(ROUND_COUNT - 1)), "round count beyond last round")

endmodule

// ===== rtl/tea_ctr_stream_cipher_top.sv =====
// Top level of the TEA counter-mode byte stream cipher.
// Instantiates teactr_front, teactr_fifo and teactr_back; depends on teactr_pkg.
//
// Input bytes enter through a queue port: a request is taken when push is high
// and full is low; stream_start with a byte restarts the counter at zero.
// Results leave through a queue port: out_byte is valid while empty is low and
// is taken when pop is high. Settings (key words, nonce) are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. The user must
// see that writes are made only while no request is in flight; the block does not
// enforce this. A byte that reuses the current keystream block passes through the
// item queue and the result queue without waiting for the round unit. A byte that
// needs a new block waits for the round unit, which does one TEA round per cycle;
// the next block is computed ahead while the current one is used. A restart or
// settings write throws away the prefetched block, which must then be built anew.
// Reset clears the key, nonce and counter and marks the block as used up.
// When the receiver stalls, results fill the output queue, then the input
// queue fills and full rises; nothing is dropped.

module tea_ctr_stream_cipher_top #(
    parameter int ROUND_COUNT = teactr_pkg::ROUND_COUNT_DEF,
    parameter int QUEUE_DEPTH = teactr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         data_byte,
    input  logic                               stream_start,
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         out_byte,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [teactr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                        cfg_data
);

    logic                   q_wr;
    teactr_pkg::item_t      q_item;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_rd;
    teactr_pkg::item_t      q_head;
    logic                   res_wr;
    logic                   res_full;
    logic [7:0]             res_data;
    teactr_pkg::cfg_write_t cfg;

    assign cfg_ready  = 1'b1;
    assign cfg.valid  = cfg_valid;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;
    assign full       = q_full;

    teactr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .data_byte    (data_byte),
        .stream_start (stream_start),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_item       (q_item)
    );

    teactr_fifo #(
        .WIDTH (teactr_pkg::ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_item),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    teactr_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (!q_empty),
        .head       (q_head),
        .head_pop   (q_rd),
        .out_full   (res_full),
        .out_wr     (res_wr),
        .out_data   (res_data)
    );

    teactr_fifo #(
        .WIDTH (8),
        .DEPTH (teactr_pkg::OUT_QUEUE_DEPTH_DEF)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_byte),
        .empty   (empty)
    );

endmodule

// ===== verif/tea_ctr_stream_cipher_top_tb.sv =====
// Self-checking testbench for the TEA counter-mode byte stream cipher top level.
// Holds its own TEA keystream predictor in a small scoreboard class; depends on
// teactr_pkg and tea_ctr_stream_cipher_top.
module tea_ctr_stream_cipher_top_tb;

    localparam int ROUND_COUNT = 32;
    localparam logic [teactr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = teactr_pkg::CFG_INDEX_W'(7);

    class keystream_scoreboard;
        localparam int          ROUNDS = ROUND_COUNT;
        localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
        localparam logic [3:0]  BYTES_PER_BLOCK = 4'd8;

        logic [31:0] key [4];
        logic [31:0] nonce;
        logic [31:0] counter;
        logic [63:0] keystream;
        logic [3:0]  position;
        logic [7:0]  expected_bytes [$];
        int          errors;

        function new();
            foreach (key[i]) key[i] = '0;
            nonce     = '0;
            counter   = '0;
            keystream = '0;
            position  = BYTES_PER_BLOCK;
            errors    = 0;
        endfunction

        function logic [63:0] encrypt_block(input logic [31:0] v0, input logic [31:0] v1);
            logic [31:0] sum;
            sum = '0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                sum = sum + GOLDEN_RATIO;
                v0 = v0 + (((v1 << 4) + key[0]) ^ (v1 + sum) ^ ((v1 >> 5) + key[1]));
                v1 = v1 + (((v0 << 4) + key[2]) ^ (v0 + sum) ^ ((v0 >> 5) + key[3]));
            end
            return {v1, v0};
        endfunction

        function void write_reg(input logic [teactr_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [31:0] value);
            case (idx)
                teactr_pkg::CFG_KEY_WORD0: key[0] = value;
                teactr_pkg::CFG_KEY_WORD1: key[1] = value;
                teactr_pkg::CFG_KEY_WORD2: key[2] = value;
                teactr_pkg::CFG_KEY_WORD3: key[3] = value;
                teactr_pkg::CFG_NONCE:     nonce  = value;
                default: ;
            endcase
        endfunction

        // A restart throws away the rest of the current block and rebuilds block zero.
        function void note_request(input logic [7:0] data, input logic restart);
            logic [63:0] shifted;
            if (restart)
            begin
                counter  = '0;
                position = BYTES_PER_BLOCK;
            end
            if (position >= BYTES_PER_BLOCK)
            begin
                keystream = encrypt_block(nonce, counter);
                counter   = counter + 32'd1;
                position  = '0;
            end
            shifted  = keystream >> {position[2:0], 3'b000};
            position = position + 4'd1;
            expected_bytes.push_back(data ^ shifted[7:0]);
        endfunction

        function void check_result(input logic [7:0] actual);
            logic [7:0] expected;
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: no result expected, actual %02h", actual);
                errors++;
                return;
            end
            expected = expected_bytes.pop_front();
            if (actual !== expected)
            begin
                $error("out_byte mismatch: expected %02h, actual %02h", expected, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               push;
    logic                               full;
    logic [7:0]                         data_byte;
    logic                               stream_start;
    logic                               empty;
    logic                               pop;
    logic [7:0]                         out_byte;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [teactr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                        cfg_data;

    bit calm = 1'b0;
    keystream_scoreboard sb = new();

    tea_ctr_stream_cipher_top #(
        .ROUND_COUNT(ROUND_COUNT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .stream_start(stream_start),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Handshakes are sampled with the values that stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.note_request(data_byte, stream_start);
            if (pop && !empty)
                sb.check_result(out_byte);
        end
    end

    // Receiver: stall bursts mixed with long stretches of steady popping.
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                pop <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                pop <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Leaves push high so that a following request can go out back to back.
    task automatic send_request(input logic [7:0] value, input logic restart);
        push         <= 1'b1;
        data_byte    <= value;
        stream_start <= restart;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        push         <= 1'b0;
        data_byte    <= 8'($urandom);
        stream_start <= 1'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // The first edge makes sure the last accepted request is already counted.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [teactr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] k0, input logic [31:0] k1,
                                  input logic [31:0] k2, input logic [31:0] k3,
                                  input logic [31:0] nonce_value, input bit poke_unused);
        wait_drained();
        write_reg(teactr_pkg::CFG_KEY_WORD0, k0);
        write_reg(teactr_pkg::CFG_KEY_WORD1, k1);
        write_reg(teactr_pkg::CFG_KEY_WORD2, k2);
        write_reg(teactr_pkg::CFG_KEY_WORD3, k3);
        write_reg(teactr_pkg::CFG_NONCE, nonce_value);
        if (poke_unused)
            write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Mostly long runs through many blocks, with a rare restart and sender gaps
    // that are switched on and off in stretches.
    task automatic random_traffic(input int count);
        bit         gaps_on;
        logic [7:0] value;
        gaps_on = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (gaps_on && !calm && $urandom_range(0, 4) == 0)
                idle_sender($urandom_range(1, 18));
            case ($urandom_range(0, 9))
                0:       value = 8'h00;
                1:       value = 8'hff;
                default: value = 8'($urandom);
            endcase
            send_request(value, $urandom_range(0, 47) == 0);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        push         <= 1'b0;
        data_byte    <= '0;
        stream_start <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero settings after reset. The first byte finds the block used up.
        send_request(8'h00, 1'b0);
        send_request(8'hff, 1'b0);
        for (int i = 0; i < 6; i++)
            send_request(8'($urandom), 1'b0);
        send_request(8'ha5, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hff, 1'b0);
        // Restart in the middle of a block, then twice in a row.
        send_request(8'hff, 1'b1);
        send_request(8'h00, 1'b1);
        for (int i = 0; i < 7; i++)
            send_request(8'($urandom), 1'b0);
        // Restart exactly at a block boundary.
        send_request(8'h5a, 1'b1);
        random_traffic(230);

        // New settings land mid-block: the old keystream runs out first.
        apply_settings('1, '1, '1, '1, '1, 1'b1);
        random_traffic(250);

        apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        random_traffic(250);

        apply_settings('0, '1, '0, '1, '1, 1'b0);
        random_traffic(250);

        apply_settings($urandom, $urandom, $urandom, $urandom, '0, 1'b0);
        random_traffic(125);
        calm = 1'b1;
        random_traffic(125);

        wait_drained();
        repeat (ROUND_COUNT + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== tea_ctr_stream_cipher_top.f =====
+incdir+rtl
rtl/teactr_pkg.sv
rtl/teactr_fifo.sv
rtl/teactr_front.sv
rtl/teactr_back.sv
rtl/tea_ctr_stream_cipher_top.sv
verif/tea_ctr_stream_cipher_top_tb.sv
